@@ sv/tkh_pkg.sv @@
// Shared types and constants of the triple key hash set checker.
`default_nettype none
package tkh_pkg;
  localparam int KEY_W = 35;
  localparam int TAG_W = 24;
  localparam int BND_W = 4;
  localparam int ST_W = 3;
  localparam int CFG_W = 4;
  localparam int SLOTS_LOG2_DEF = 12;
  localparam logic [CFG_W-1:0] CFG_RST = 4'd12;

  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL = 3'd2;
  localparam logic [ST_W-1:0] ST_MATCH = 3'd3;
  localparam logic [ST_W-1:0] ST_MISSING = 3'd4;
  localparam logic [ST_W-1:0] ST_BOUND_MISMATCH = 3'd5;
  localparam logic [ST_W-1:0] ST_REPEAT = 3'd6;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam logic [63:0] OFS_LO = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] OFS_HI = 64'h243f6a8885a308d3;

  typedef struct packed {
    logic             valid;
    logic             matched;
    logic [KEY_W-1:0] outer;
    logic [KEY_W-1:0] low;
    logic [KEY_W-1:0] high;
    logic [BND_W-1:0] bound;
    logic [TAG_W-1:0] tag;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);
endpackage
`default_nettype wire

@@ sv/tkh_ram.sv @@
// Generic single write port RAM with registered read.
`default_nettype none
module tkh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ sv/tkh_hash.sv @@
// Iterative key hash: three mix finalizers on one shared 32x32 multiplier.
`default_nettype none
module tkh_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] v0_i,
  input  wire logic [63:0] v1_i,
  input  wire logic [63:0] v2_i,
  output logic             done_o,
  output logic [63:0]      hash_o
);
  import tkh_pkg::*;

  localparam logic [1:0] PH_P0 = 2'd0;
  localparam logic [1:0] PH_P1 = 2'd1;
  localparam logic [1:0] PH_P2 = 2'd2;
  localparam logic [1:0] PH_IDLE = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic        k_q, k_d;
  logic        done_q, done_d;
  logic [63:0] v_q, v_d, acc_q, acc_d, h_q, h_d;
  logic [63:0] cst, prod, sum, fin, nxt;
  logic [31:0] ma, mc;

  always_comb begin
    cst = k_q ? MIX_C2 : MIX_C1;
    ma = (phase_q == PH_P1) ? v_q[63:32] : v_q[31:0];
    mc = (phase_q == PH_P2) ? cst[63:32] : cst[31:0];
    prod = 64'(ma) * 64'(mc);
    sum = acc_q + {prod[31:0], 32'd0};
    fin = sum ^ (sum >> 31);
    nxt = (idx_q == 2'd0) ? v1_i : v2_i;
    phase_d = phase_q;
    idx_d = idx_q;
    k_d = k_q;
    v_d = v_q;
    acc_d = acc_q;
    h_d = h_q;
    done_d = 1'b0;
    if (start_i) begin
      phase_d = PH_P0;
      idx_d = 2'd0;
      k_d = 1'b0;
      h_d = '0;
      v_d = v0_i ^ (v0_i >> 30);
    end else begin
      unique case (phase_q)
        PH_P0: begin
          acc_d = prod;
          phase_d = PH_P1;
        end
        PH_P1: begin
          acc_d = sum;
          phase_d = PH_P2;
        end
        PH_P2: begin
          phase_d = PH_P0;
          if (!k_q) begin
            v_d = sum ^ (sum >> 27);
            k_d = 1'b1;
          end else begin
            h_d = h_q ^ fin;
            k_d = 1'b0;
            if (idx_q == 2'd2) begin
              phase_d = PH_IDLE;
              done_d = 1'b1;
            end else begin
              idx_d = idx_q + 2'd1;
              v_d = nxt ^ (nxt >> 30);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q <= '0;
      k_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q <= idx_d;
      k_q <= k_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    acc_q <= acc_d;
    h_q <= h_d;
  end

  assign done_o = done_q;
  assign hash_o = h_q;
endmodule
`default_nettype wire

@@ sv/triple_key_hash_set_checker.sv @@
// Top level of the triple key hash set checker: probe sequencer and slot table.
// Usage:
//  Slave stream carries one request: tuser is the request type (0 insert,
//  1 check), tdata packs the three key parts, the bound and the tag.
//  Master stream returns one result per request: tuser is the status code,
//  tdata packs the stored tag and bound.
//  cfg_we_i/cfg_wdata_i set log2 of the active slot count (saturated to
//  SLOTS_LOG2); write it only while no request is in flight.
//  A request is accepted, hashed in the shared-multiplier hash unit (three
//  mix rounds of six multiply steps plus start and done), then probed slot
//  by slot (table read, compare) from its home slot, and its result handed
//  off; the next request is taken only after that hand-off. The probe walk
//  can cover every active slot on a crowded table.
//  After reset all 2^SLOTS_LOG2 slots are swept clear, during which
//  s_axis_tready stays low; configuration writes are taken meanwhile.
//  A finished result sits in the output register; a new request is taken
//  while it waits, but the next result waits for the master to drain.
`default_nettype none
module triple_key_hash_set_checker #(
  parameter int SLOTS_LOG2 = tkh_pkg::SLOTS_LOG2_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [tkh_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // part_l, part_m, part_n, bound_value, entry_tag, zero pad
  input  wire logic [135:0]             s_axis_tdata,
  // req_type
  input  wire logic [0:0]               s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // stored_tag, stored_bound, zero pad
  output logic [31:0]                   m_axis_tdata,
  // status
  output logic [tkh_pkg::ST_W-1:0]      m_axis_tuser
);
  import tkh_pkg::*;

  localparam int AW = SLOTS_LOG2;
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HASH = 3'd2;
  localparam logic [2:0] S_RD = 3'd3;
  localparam logic [2:0] S_CMP = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CFG_W-1:0] cfg_q;
  logic [AW-1:0]    pos_q, pos_d, n_q, n_d, clr_q, clr_d;
  logic             hstart_q;
  logic             chk_q;
  logic [KEY_W-1:0] ko_q, lo_q, hi_q;
  logic [BND_W-1:0] bnd_q;
  logic [TAG_W-1:0] tag_q;
  logic [ST_W-1:0]  rst_q, rst_d;
  logic [TAG_W-1:0] rtag_q, rtag_d;
  logic [BND_W-1:0] rbnd_q, rbnd_d;
  logic             mv_q, mv_d;
  logic [ST_W-1:0]  ms_q;
  logic [TAG_W-1:0] mtag_q;
  logic [BND_W-1:0] mbnd_q;

  logic             accept, hdone, we, hit, eqk;
  logic [63:0]      hash;
  logic [AW-1:0]    waddr, mask;
  logic [AW:0]      one_sh;
  logic [4:0]       eff_lg;
  slot_t            rd, wd;
  logic [SLOT_W-1:0] rdata;
  logic [KEY_W-1:0] in_m, in_n;

  assign in_m = s_axis_tdata[69:35];
  assign in_n = s_axis_tdata[104:70];
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    eff_lg = (int'(cfg_q) > SLOTS_LOG2) ? 5'(SLOTS_LOG2) : 5'(cfg_q);
    one_sh = (AW + 1)'(1) << eff_lg;
    mask = AW'(one_sh - (AW + 1)'(1));
  end

  tkh_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hstart_q),
    .v0_i   ({29'd0, ko_q}),
    .v1_i   ({29'd0, lo_q} + OFS_LO),
    .v2_i   ({29'd0, hi_q} + OFS_HI),
    .done_o (hdone),
    .hash_o (hash)
  );

  tkh_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(1 << SLOTS_LOG2)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wd),
    .raddr_i(pos_q),
    .rdata_o(rdata)
  );

  assign rd = slot_t'(rdata);
  assign eqk = (rd.outer == ko_q) && (rd.low == lo_q) && (rd.high == hi_q);
  assign hit = !rd.valid || eqk;

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    n_d = n_q;
    clr_d = clr_q;
    rst_d = rst_q;
    rtag_d = rtag_q;
    rbnd_d = rbnd_q;
    mv_d = mv_q && !m_axis_tready;
    we = 1'b0;
    waddr = pos_q;
    wd = rd;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_q;
        wd = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == {AW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hdone) begin
          pos_d = hash[AW-1:0] & mask;
          n_d = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        rtag_d = '0;
        rbnd_d = '0;
        if (hit) begin
          state_d = S_FIN;
          if (!chk_q) begin
            if (rd.valid) begin
              rst_d = ST_DUPLICATE;
              rtag_d = rd.tag;
              rbnd_d = rd.bound;
            end else begin
              rst_d = ST_INSERTED;
              we = 1'b1;
              wd.valid = 1'b1;
              wd.matched = 1'b0;
              wd.outer = ko_q;
              wd.low = lo_q;
              wd.high = hi_q;
              wd.bound = bnd_q;
              wd.tag = tag_q;
            end
          end else if (!rd.valid) begin
            rst_d = ST_MISSING;
          end else begin
            rtag_d = rd.tag;
            rbnd_d = rd.bound;
            if (rd.matched) begin
              rst_d = ST_REPEAT;
            end else begin
              we = 1'b1;
              wd.matched = 1'b1;
              rst_d = (rd.bound == bnd_q) ? ST_MATCH : ST_BOUND_MISMATCH;
            end
          end
        end else if (n_q == mask) begin
          state_d = S_FIN;
          rst_d = chk_q ? ST_MISSING : ST_FULL;
        end else begin
          pos_d = (pos_q + AW'(1)) & mask;
          n_d = n_q + AW'(1);
          state_d = S_RD;
        end
      end
      S_FIN: begin
        if (!mv_q || m_axis_tready) begin
          mv_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cfg_q <= CFG_RST;
      clr_q <= '0;
      hstart_q <= 1'b0;
      mv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      hstart_q <= accept;
      mv_q <= mv_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    n_q <= n_d;
    rst_q <= rst_d;
    rtag_q <= rtag_d;
    rbnd_q <= rbnd_d;
    if (accept) begin
      chk_q <= s_axis_tuser[0];
      ko_q <= s_axis_tdata[34:0];
      lo_q <= (in_m < in_n) ? in_m : in_n;
      hi_q <= (in_m < in_n) ? in_n : in_m;
      bnd_q <= s_axis_tdata[108:105];
      tag_q <= s_axis_tdata[132:109];
    end
    if (state_q == S_FIN && (!mv_q || m_axis_tready)) begin
      ms_q <= rst_q;
      mtag_q <= rtag_q;
      mbnd_q <= rbnd_q;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tuser = ms_q;
  assign m_axis_tdata = {4'd0, mbnd_q, mtag_q};
endmodule
`default_nettype wire

@@ sv/tkh_checker.sv @@
// Port-level assertions for the triple key hash set checker, with bind.
`default_nettype none
module tkh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);
  import tkh_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 3'd7)
    else $error("undefined status");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_INSERTED || m_axis_tuser == ST_FULL ||
      m_axis_tuser == ST_MISSING) |-> m_axis_tdata == 32'd0)
    else $error("tag or bound reported without a found entry");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");
endmodule

bind triple_key_hash_set_checker tkh_checker u_tkh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire

@@ test/triple_key_hash_set_checker_tb.sv @@
// Testbench for the triple key hash set checker: directed rows, then random traffic.
`timescale 1ns / 1ps
`default_nettype none
module triple_key_hash_set_checker_tb;
  import tkh_pkg::*;

  localparam int DEPTH = 1 << SLOTS_LOG2_DEF;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [4:0] NO_CFG = 5'h1f;
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_CHECK = 1'b1;
  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] part_l;
    logic [KEY_W-1:0] part_m;
    logic [KEY_W-1:0] part_n;
    logic [BND_W-1:0] bound;
    logic [TAG_W-1:0] tag;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [TAG_W-1:0] tag;
    logic [BND_W-1:0] bound;
  } result_t;

  typedef struct packed {
    logic [4:0] cfg;
    request_t   req;
    logic       known;
    result_t    res;
  } dir_row_t;

  typedef struct packed {
    logic [KEY_W-1:0] part_l;
    logic [KEY_W-1:0] part_m;
    logic [KEY_W-1:0] part_n;
    logic [BND_W-1:0] bound;
  } key_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [ST_W-1:0] m_axis_tuser;

  triple_key_hash_set_checker dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the slot table
  logic             sh_valid[DEPTH];
  logic             sh_matched[DEPTH];
  logic [KEY_W-1:0] sh_outer[DEPTH];
  logic [KEY_W-1:0] sh_low[DEPTH];
  logic [KEY_W-1:0] sh_high[DEPTH];
  logic [BND_W-1:0] sh_bound[DEPTH];
  logic [TAG_W-1:0] sh_tag[DEPTH];
  int unsigned      active_log2 = SLOTS_LOG2_DEF;

  result_t pending_results[$];
  key_entry_t key_pool[$];
  int errors = 0;
  bit no_idle = 1'b0;
  bit hold_sink = 1'b0;
  int quiet_cycles = 0;

  function automatic logic [63:0] finalize64(logic [63:0] v);
    v = v ^ (v >> 30);
    v = v * MIX_C1;
    v = v ^ (v >> 27);
    v = v * MIX_C2;
    return v ^ (v >> 31);
  endfunction

  function automatic result_t hash_set_access(request_t r);
    logic [KEY_W-1:0] lo, hi;
    logic [63:0] h;
    int unsigned size, mask, pos, n;
    bit found;
    result_t o;
    lo = (r.part_m < r.part_n) ? r.part_m : r.part_n;
    hi = (r.part_m < r.part_n) ? r.part_n : r.part_m;
    h = finalize64(64'(r.part_l)) ^ finalize64(64'(lo) + OFS_LO) ^
        finalize64(64'(hi) + OFS_HI);
    size = 1 << active_log2;
    mask = size - 1;
    pos = h[31:0] & mask;
    found = 1'b0;
    o = '0;
    for (n = 0; n < size && !found; n++) begin
      if (!sh_valid[pos] || (sh_outer[pos] == r.part_l && sh_low[pos] == lo &&
                             sh_high[pos] == hi))
        found = 1'b1;
      else
        pos = (pos + 1) & mask;
    end
    if (r.kind == KIND_INSERT) begin
      if (!found) begin
        o.status = ST_FULL;
      end else if (sh_valid[pos]) begin
        o.status = ST_DUPLICATE;
        o.tag = sh_tag[pos];
        o.bound = sh_bound[pos];
      end else begin
        sh_valid[pos] = 1'b1;
        sh_matched[pos] = 1'b0;
        sh_outer[pos] = r.part_l;
        sh_low[pos] = lo;
        sh_high[pos] = hi;
        sh_bound[pos] = r.bound;
        sh_tag[pos] = r.tag;
        o.status = ST_INSERTED;
      end
    end else if (!found || !sh_valid[pos]) begin
      o.status = ST_MISSING;
    end else begin
      o.tag = sh_tag[pos];
      o.bound = sh_bound[pos];
      if (sh_matched[pos]) begin
        o.status = ST_REPEAT;
      end else begin
        sh_matched[pos] = 1'b1;
        o.status = (sh_bound[pos] == r.bound) ? ST_MATCH : ST_BOUND_MISMATCH;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic send_request(input request_t r, input bit known, input result_t res);
    result_t p;
    while (!no_idle && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.kind;
    s_axis_tdata <= {3'b0, r.tag, r.bound, r.part_n, r.part_m, r.part_l};
    do @(posedge clk_i); while (!s_axis_tready);
    p = hash_set_access(r);
    pending_results.insert(pending_results.size(), known ? res : p);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    active_log2 = (v > SLOTS_LOG2_DEF) ? SLOTS_LOG2_DEF : v;
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'({$urandom, $urandom});
  endfunction

  function automatic request_t rand_request();
    request_t r;
    key_entry_t k;
    int sel;
    r.kind = 1'($urandom_range(1));
    r.tag = TAG_W'($urandom);
    r.bound = BND_W'($urandom);
    sel = $urandom_range(99);
    if (key_pool.size() == 0 || sel < 35) begin
      r.part_l = rand_key();
      r.part_m = rand_key();
      r.part_n = rand_key();
      if (r.kind == KIND_INSERT && key_pool.size() < 2000)
        key_pool.insert(key_pool.size(), {r.part_l, r.part_m, r.part_n, r.bound});
    end else begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
      r.part_l = k.part_l;
      if ($urandom_range(1)) begin
        r.part_m = k.part_m;
        r.part_n = k.part_n;
      end else begin
        r.part_m = k.part_n;
        r.part_n = k.part_m;
      end
      if ($urandom_range(99) < 65) r.bound = k.bound;
    end
    return r;
  endfunction

  dir_row_t dir_rows[16] = '{
    '{NO_CFG, '{KIND_CHECK, 35'h123456789, 35'h1, 35'h2, 4'h3, 24'h5}, 1'b1,
      '{ST_MISSING, 24'h0, 4'h0}},
    '{NO_CFG, '{KIND_INSERT, KEY_ONES, 35'h5, KEY_ONES, 4'hf, 24'hffffff}, 1'b1,
      '{ST_INSERTED, 24'h0, 4'h0}},
    '{NO_CFG, '{KIND_INSERT, KEY_ONES, KEY_ONES, 35'h5, 4'h0, 24'h1}, 1'b1,
      '{ST_DUPLICATE, 24'hffffff, 4'hf}},
    '{NO_CFG, '{KIND_CHECK, KEY_ONES, KEY_ONES, 35'h5, 4'hf, 24'h0}, 1'b1,
      '{ST_MATCH, 24'hffffff, 4'hf}},
    '{NO_CFG, '{KIND_CHECK, KEY_ONES, 35'h5, KEY_ONES, 4'hf, 24'h7}, 1'b1,
      '{ST_REPEAT, 24'hffffff, 4'hf}},
    '{NO_CFG, '{KIND_INSERT, 35'h0, 35'h0, 35'h0, 4'h0, 24'h0}, 1'b1,
      '{ST_INSERTED, 24'h0, 4'h0}},
    '{NO_CFG, '{KIND_CHECK, 35'h0, 35'h0, 35'h0, 4'h3, 24'hffffff}, 1'b1,
      '{ST_BOUND_MISMATCH, 24'h0, 4'h0}},
    '{NO_CFG, '{KIND_INSERT, KEY_ONES, KEY_ONES, KEY_ONES, 4'ha, 24'h555555}, 1'b1,
      '{ST_INSERTED, 24'h0, 4'h0}},
    '{5'd0, '{KIND_INSERT, 35'h11, 35'h22, 35'h33, 4'h1, 24'h10}, 1'b0, '0},
    '{NO_CFG, '{KIND_INSERT, 35'h44, 35'h55, 35'h66, 4'h2, 24'h20}, 1'b0, '0},
    '{NO_CFG, '{KIND_CHECK, 35'h44, 35'h66, 35'h55, 4'h2, 24'h0}, 1'b0, '0},
    '{5'd1, '{KIND_INSERT, 35'h77, 35'h1, 35'h9, 4'h3, 24'h30}, 1'b0, '0},
    '{NO_CFG, '{KIND_INSERT, 35'h78, 35'h2, 35'h9, 4'h4, 24'h40}, 1'b0, '0},
    '{NO_CFG, '{KIND_INSERT, 35'h79, 35'h3, 35'h9, 4'h5, 24'h50}, 1'b0, '0},
    '{5'd15, '{KIND_CHECK, 35'h0, 35'h0, 35'h0, 4'h0, 24'h0}, 1'b0, '0},
    '{NO_CFG, '{KIND_CHECK, 35'h11, 35'h33, 35'h22, 4'h1, 24'h0}, 1'b0, '0}
  };

  int phase_size[7] = '{3, 12, 15, 6, 0, 12, 9};

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(m_axis_tuser), 32'd0);
        end else begin
          result_t w;
          w = pending_results.pop_front();
          if (m_axis_tuser !== w.status)
            report_mismatch("status", 32'(m_axis_tuser), 32'(w.status));
          if (m_axis_tdata[23:0] !== w.tag)
            report_mismatch("tag", 32'(m_axis_tdata[23:0]), 32'(w.tag));
          if (m_axis_tdata[27:24] !== w.bound)
            report_mismatch("bound", 32'(m_axis_tdata[27:24]), 32'(w.bound));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("triple_key_hash_set_checker: mismatch");
        $finish;
      end
    end
  end

  // Result sink with random back-pressure and one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 28);
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      sh_valid[i] = 1'b0;
      sh_matched[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != NO_CFG) write_size(dir_rows[i].cfg[CFG_W-1:0]);
      send_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);
    end
    foreach (phase_size[p]) begin
      write_size(CFG_W'(phase_size[p]));
      no_idle = (p == 3);
      if (p == 1) hold_sink = 1'b1;
      repeat (170) send_request(rand_request(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0)
      $display("triple_key_hash_set_checker: match");
    else
      $display("triple_key_hash_set_checker: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
